@@ rtl/tps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes for the tensor pad source index generator.
// No dependencies; imported by every module of the block.
package tps_pkg;

    // field and datapath widths
    localparam int BATCH_W = 6;
    localparam int CHAN_W  = 10;
    localparam int OUTC_W  = 14;               // padded row / column
    localparam int DIM_W   = 13;               // height / width register
    localparam int CCNT_W  = 11;               // channel count register
    localparam int PAD_W   = 12;               // pad_top / pad_left
    localparam int WORD_W  = 32;               // fill word, widest register
    localparam int IDX_W   = 40;               // linear source index
    localparam int SGN_W   = OUTC_W + 1;       // signed source coordinate
    localparam int MAG_W   = OUTC_W;           // |coordinate| and reflect period
    localparam int BC_W    = BATCH_W + CCNT_W + 1;  // batch*count + channel
    localparam int M1_W    = BC_W + DIM_W;          // (..)*height
    localparam int SUM_W   = M1_W + 1;              // (..)*height + row
    localparam int RIDX_W  = 3;                     // register index

    // pipeline layout: two front stages, one remainder stage per bit, four back stages
    localparam int NDIV    = MAG_W;
    localparam int DIV0    = 2;
    localparam int IDX0    = DIV0 + NDIV;
    localparam int NBACK   = 4;
    localparam int NST     = IDX0 + NBACK;

    // padding modes; the unused code behaves as constant fill
    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_REFL  = 2'd2;

    // configuration register indexes
    typedef enum logic [RIDX_W-1:0] {
        REG_PAD_MODE  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_IN_WIDTH  = 3'd2,
        REG_CHAN_CNT  = 3'd3,
        REG_PAD_TOP   = 3'd4,
        REG_PAD_LEFT  = 3'd5,
        REG_FILL_VAL  = 3'd6
    } t_reg_idx;

    // derived geometry; user keeps it stable while requests are in flight, unchecked
    typedef struct packed {
        logic [1:0]        mode;
        logic [DIM_W-1:0]  heff;     // height, zero taken as one
        logic [DIM_W-1:0]  weff;
        logic [MAG_W-1:0]  hper;     // reflect period 2*(heff-1)
        logic [MAG_W-1:0]  wper;
        logic [WORD_W-1:0] fill_value;
    } t_shape;

    // per-request sideband carried alongside the remainder stages
    typedef struct packed {
        logic                    fill;
        logic                    in_range;
        logic signed [SGN_W-1:0] row_s;
        logic signed [SGN_W-1:0] col_s;
        logic [BC_W-1:0]         bc;
    } t_side;

endpackage

@@ rtl/tps_mod_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring remainder: one quotient bit resolved per register stage.
// Depends on tps_pkg; stage enables come from the top-level flow control.
module tps_mod_pipe (
    input  logic                       i_clk,
    input  logic [tps_pkg::NDIV-1:0]   i_en,
    input  logic [tps_pkg::MAG_W-1:0]  i_num,
    input  logic [tps_pkg::MAG_W-1:0]  i_per,
    output logic [tps_pkg::MAG_W-1:0]  o_rem
);
    import tps_pkg::*;

    logic [MAG_W-1:0] r_rem [NDIV];

    genvar j;
    generate
        for (j = 0; j < NDIV; j++) begin : g_stage
            logic [2*MAG_W-1:0] w_trial;
            logic [MAG_W-1:0]   w_in;
            logic [MAG_W-1:0]   n_rem;

            if (j == 0) begin : g_first
                assign w_in = i_num;
            end else begin : g_next
                assign w_in = r_rem[j-1];
            end

            // period shifted to the bit this stage decides
            assign w_trial = {{MAG_W{1'b0}}, i_per} << (NDIV - 1 - j);
            assign n_rem   = ({{MAG_W{1'b0}}, w_in} >= w_trial)
                             ? w_in - w_trial[MAG_W-1:0] : w_in;

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem;
                end
            end
        end
    endgenerate

    assign o_rem = r_rem[NDIV-1];

endmodule

@@ rtl/tps_index.sv @@
`timescale 1ns / 1ps
// Back end: coordinate folding, then the linear index multiply-add chain.
// Depends on tps_pkg; four register stages enabled by the top-level flow control.
module tps_index (
    input  logic                        i_clk,
    input  logic [tps_pkg::NBACK-1:0]   i_en,
    input  tps_pkg::t_side              i_side,
    input  logic [tps_pkg::MAG_W-1:0]   i_rem_row,
    input  logic [tps_pkg::MAG_W-1:0]   i_rem_col,
    input  tps_pkg::t_shape             i_shape,
    output logic [tps_pkg::IDX_W-1:0]   o_source_index,
    output logic                        o_use_fill,
    output logic [tps_pkg::WORD_W-1:0]  o_fill_word
);
    import tps_pkg::*;

    // map an outside coordinate back into [0, dim)
    function automatic logic [DIM_W-1:0] fold(
        input logic [MAG_W-1:0]        rem,
        input logic signed [SGN_W-1:0] v,
        input logic                    in_range,
        input logic [DIM_W-1:0]        dim,
        input logic [MAG_W-1:0]        per,
        input logic [1:0]              mode
    );
        logic [DIM_W-1:0] res;
        res = v[DIM_W-1:0];
        if (!in_range) begin
            if (mode == MODE_REFL) begin
                if (dim <= DIM_W'(1)) begin
                    res = '0;
                end else if (rem >= {{(MAG_W-DIM_W){1'b0}}, dim}) begin
                    res = DIM_W'(per - rem);
                end else begin
                    res = rem[DIM_W-1:0];
                end
            end else begin
                // edge clamp; fill requests ignore the coordinate
                if (v[SGN_W-1]) begin
                    res = '0;
                end else if (v >= $signed({{(SGN_W-DIM_W){1'b0}}, dim})) begin
                    res = dim - DIM_W'(1);
                end else begin
                    res = v[DIM_W-1:0];
                end
            end
        end
        return res;
    endfunction

    logic [DIM_W-1:0]  r_row_f, r_col_f, r_col_2, r_col_3;
    logic [M1_W-1:0]   r_m1;
    logic [SUM_W-1:0]  r_sum;
    logic [IDX_W-1:0]  r_m2;
    logic              r_fill_1, r_fill_2, r_fill_3;
    logic [IDX_W-1:0]  r_idx;
    logic              r_use_fill;
    logic [WORD_W-1:0] r_fill_word;

    logic [M1_W-1:0]       n_m1;
    logic [SUM_W+DIM_W-1:0] n_m2_full;

    assign n_m1      = {{DIM_W{1'b0}}, i_side.bc} * {{BC_W{1'b0}}, i_shape.heff};
    assign n_m2_full = {{DIM_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, i_shape.weff};

    // fold stage, batch/channel times height in parallel
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_row_f  <= fold(i_rem_row, i_side.row_s, i_side.in_range, i_shape.heff,
                             i_shape.hper, i_shape.mode);
            r_col_f  <= fold(i_rem_col, i_side.col_s, i_side.in_range, i_shape.weff,
                             i_shape.wper, i_shape.mode);
            r_m1     <= n_m1;
            r_fill_1 <= i_side.fill;
        end
    end

    // add row
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_sum    <= {1'b0, r_m1} + {{(SUM_W-DIM_W){1'b0}}, r_row_f};
            r_col_2  <= r_col_f;
            r_fill_2 <= r_fill_1;
        end
    end

    // times width, wrapped to the index width
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m2     <= n_m2_full[IDX_W-1:0];
            r_col_3  <= r_col_2;
            r_fill_3 <= r_fill_2;
        end
    end

    // add column, output register
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_idx       <= r_fill_3 ? '0
                           : r_m2 + {{(IDX_W-DIM_W){1'b0}}, r_col_3};
            r_use_fill  <= r_fill_3;
            r_fill_word <= r_fill_3 ? i_shape.fill_value : '0;
        end
    end

    assign o_source_index = r_idx;
    assign o_use_fill     = r_use_fill;
    assign o_fill_word    = r_fill_word;

endmodule

@@ rtl/tensor_pad_source_index.sv @@
`timescale 1ns / 1ps
// Top level of the tensor pad source index generator: config registers,
// front stages, flow control. Depends on tps_pkg, tps_mod_pipe, tps_index.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  request | in        | i_valid / o_ready    | batch, channel, out row, out column
//  result  | out       | o_valid / i_ready    | source index, use fill, fill word
//  config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// One request per cycle sustained while i_ready holds; two front stages, 14 remainder
// stages (one bit each, sets the depth) and four fold/multiply-add stages.
// Every stage has a valid bit and advances when empty or when the next stage moves,
// so bubbles close up under a stall and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and restores register defaults.
module tensor_pad_source_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tps_pkg::RIDX_W-1:0]    i_cfg_idx,
    input  logic [tps_pkg::WORD_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tps_pkg::BATCH_W-1:0]   i_batch_index,
    input  logic [tps_pkg::CHAN_W-1:0]    i_channel_index,
    input  logic [tps_pkg::OUTC_W-1:0]    i_out_row,
    input  logic [tps_pkg::OUTC_W-1:0]    i_out_col,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tps_pkg::IDX_W-1:0]     o_source_index,
    output logic                          o_use_fill,
    output logic [tps_pkg::WORD_W-1:0]    o_fill_word
);
    import tps_pkg::*;

    // configuration registers
    logic [1:0]        r_pad_mode;
    logic [DIM_W-1:0]  r_in_height, r_in_width;
    logic [CCNT_W-1:0] r_chan_cnt;
    logic [PAD_W-1:0]  r_pad_top, r_pad_left;
    logic [WORD_W-1:0] r_fill_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode   <= MODE_CONST;
            r_in_height  <= DIM_W'(1);
            r_in_width   <= DIM_W'(1);
            r_chan_cnt   <= CCNT_W'(1);
            r_pad_top    <= '0;
            r_pad_left   <= '0;
            r_fill_value <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PAD_MODE:  r_pad_mode   <= i_cfg_wdata[1:0];
                REG_IN_HEIGHT: r_in_height  <= i_cfg_wdata[DIM_W-1:0];
                REG_IN_WIDTH:  r_in_width   <= i_cfg_wdata[DIM_W-1:0];
                REG_CHAN_CNT:  r_chan_cnt   <= i_cfg_wdata[CCNT_W-1:0];
                REG_PAD_TOP:   r_pad_top    <= i_cfg_wdata[PAD_W-1:0];
                REG_PAD_LEFT:  r_pad_left   <= i_cfg_wdata[PAD_W-1:0];
                REG_FILL_VAL:  r_fill_value <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived geometry
    t_shape           w_shape;
    logic [DIM_W-1:0] w_hm1, w_wm1;

    always_comb begin
        w_shape.mode       = r_pad_mode;
        w_shape.heff       = (r_in_height == '0) ? DIM_W'(1) : r_in_height;
        w_shape.weff       = (r_in_width == '0) ? DIM_W'(1) : r_in_width;
        w_hm1              = w_shape.heff - DIM_W'(1);
        w_wm1              = w_shape.weff - DIM_W'(1);
        w_shape.hper       = {w_hm1, 1'b0};
        w_shape.wper       = {w_wm1, 1'b0};
        w_shape.fill_value = r_fill_value;
    end

    // stage valid bits and per-stage advance
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    assign w_en[NST-1] = !r_vld[NST-1] || i_ready;
    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];

    // stage 0: remove the pads
    logic signed [SGN_W-1:0] r0_row_s, r0_col_s;
    logic [BATCH_W-1:0]      r0_batch;
    logic [CHAN_W-1:0]       r0_chan;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_row_s <= {1'b0, i_out_row} - {{(SGN_W-PAD_W){1'b0}}, r_pad_top};
            r0_col_s <= {1'b0, i_out_col} - {{(SGN_W-PAD_W){1'b0}}, r_pad_left};
            r0_batch <= i_batch_index;
            r0_chan  <= i_channel_index;
        end
    end

    // stage 1: magnitudes, bounds test, batch/channel term
    t_side            n1_side;
    t_side            r1_side;
    logic [MAG_W-1:0] r1_abs_row, r1_abs_col;
    logic             w_in_row, w_in_col;
    logic             w_refl_or_edge;

    always_comb begin
        w_in_row = !r0_row_s[SGN_W-1]
                   && (r0_row_s[MAG_W-1:0] < {{(MAG_W-DIM_W){1'b0}}, r_in_height});
        w_in_col = !r0_col_s[SGN_W-1]
                   && (r0_col_s[MAG_W-1:0] < {{(MAG_W-DIM_W){1'b0}}, r_in_width});
        w_refl_or_edge = (r_pad_mode == MODE_EDGE) || (r_pad_mode == MODE_REFL);
        n1_side.in_range = w_in_row && w_in_col;
        n1_side.fill     = !(w_in_row && w_in_col) && !w_refl_or_edge;
        n1_side.row_s    = r0_row_s;
        n1_side.col_s    = r0_col_s;
        n1_side.bc       = BC_W'(r0_batch) * BC_W'(r_chan_cnt)
                           + {{(BC_W-CHAN_W){1'b0}}, r0_chan};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_side    <= n1_side;
            r1_abs_row <= r0_row_s[SGN_W-1] ? MAG_W'(-r0_row_s) : r0_row_s[MAG_W-1:0];
            r1_abs_col <= r0_col_s[SGN_W-1] ? MAG_W'(-r0_col_s) : r0_col_s[MAG_W-1:0];
        end
    end

    // sideband alongside the remainder stages
    t_side r_dv [NDIV];

    genvar j;
    generate
        for (j = 0; j < NDIV; j++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_en[DIV0+j]) begin
                    if (j == 0) begin
                        r_dv[j] <= r1_side;
                    end else begin
                        r_dv[j] <= r_dv[(j == 0) ? 0 : j-1];
                    end
                end
            end
        end
    endgenerate

    // reflect remainders, |row| mod 2(h-1) and |col| mod 2(w-1)
    logic [MAG_W-1:0] w_rem_row, w_rem_col;

    tps_mod_pipe u_mod_row (
        .i_clk (i_clk),
        .i_en  (w_en[DIV0 +: NDIV]),
        .i_num (r1_abs_row),
        .i_per (w_shape.hper),
        .o_rem (w_rem_row)
    );

    tps_mod_pipe u_mod_col (
        .i_clk (i_clk),
        .i_en  (w_en[DIV0 +: NDIV]),
        .i_num (r1_abs_col),
        .i_per (w_shape.wper),
        .o_rem (w_rem_col)
    );

    // fold and linear index
    tps_index u_index (
        .i_clk          (i_clk),
        .i_en           (w_en[IDX0 +: NBACK]),
        .i_side         (r_dv[NDIV-1]),
        .i_rem_row      (w_rem_row),
        .i_rem_col      (w_rem_col),
        .i_shape        (w_shape),
        .o_source_index (o_source_index),
        .o_use_fill     (o_use_fill),
        .o_fill_word    (o_fill_word)
    );

endmodule
